/* hw/rtl/bbbu_pkg.sv */
// Shared types, constants and helpers for the binary Bayes belief update block.
// Used by bbbu_divider, binary_bayes_belief_update and the testbench; depends on nothing else.
`timescale 1ns / 1ps

package bbbu_pkg;

   // Probabilities and belief are unsigned Q1.16.
   localparam int FRAC_BITS = 16;
   localparam int PROB_W    = FRAC_BITS + 1;
   localparam int FEAT_W    = 24;
   localparam int THR_W     = 23;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 23;
   localparam int REQ_DAT_W = 24;
   localparam int RSP_DAT_W = 24;

   // Product of two probabilities, and the widths the divider works at.
   localparam int PROD_W = 2 * PROB_W;
   localparam int NUM_W  = 2 * FRAC_BITS + 1;
   localparam int ACC_W  = PROD_W + 1;

   localparam logic [PROB_W-1:0] PROB_ONE  = PROB_W'(1 << FRAC_BITS);
   localparam logic [PROB_W-1:0] PROB_HALF = PROB_W'(1 << (FRAC_BITS - 1));

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_FEATURE_THRESHOLD    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TRANS_OPEN_TO_OPEN   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TRANS_CLOSED_TO_OPEN = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SENSE_OPEN_IF_OPEN   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SENSE_OPEN_IF_CLOSED = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_DONE_BELIEF_LEVEL    = 3'd5;

   // Register reset values.
   localparam logic [THR_W-1:0]  RST_FEATURE_THRESHOLD    = 23'd114176;
   localparam logic [PROB_W-1:0] RST_TRANS_OPEN_TO_OPEN   = 17'd65536;
   localparam logic [PROB_W-1:0] RST_TRANS_CLOSED_TO_OPEN = 17'd10486;
   localparam logic [PROB_W-1:0] RST_SENSE_OPEN_IF_OPEN   = 17'd57344;
   localparam logic [PROB_W-1:0] RST_SENSE_OPEN_IF_CLOSED = 17'd18022;
   localparam logic [PROB_W-1:0] RST_DONE_BELIEF_LEVEL    = 17'd64881;

   // Control handed to the divider, and its status back.
   typedef struct packed {
      logic              start;
      logic [NUM_W-1:0]  num;
      logic [NUM_W-1:0]  den;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [PROB_W-1:0] quot;
   } div_rsp_type;

   // A probability register above one counts as one.
   function automatic logic [PROB_W-1:0] sat_prob(input logic [PROB_W-1:0] v);
      return (v > PROB_ONE) ? PROB_ONE : v;
   endfunction

endpackage

/* hw/rtl/binary_bayes_belief_update.sv */
// Top level of the two-state (open/closed) door Bayes filter.
// Depends on bbbu_pkg and bbbu_divider.
`timescale 1ns / 1ps

// Usage:
// The req_ stream carries one signed Q15.8 sensor feature per transfer. Each
// transfer produces exactly one rsp_ transfer with the open belief (Q1.16),
// the measurement used, whether the belief was rewritten, and the sticky done
// flag. A negative feature keeps the previous measurement.
// The csr_ channel writes one configuration register per transfer and is
// always ready; writes are meant to happen only while the block is idle.
// An item goes from its req_ transfer to its result on rsp_ through four
// multiply-accumulate passes through one shared 17x17 multiplier, a
// predict-clamp step, a check step, the bit-serial divider (17 quotient bits,
// then the quotient is handed back) and the load of the output register,
// which waits until that register is free. With done set the item goes
// straight to the output load; with zero evidence it skips the divider. The
// next transfer can be accepted in the cycle after the result is loaded.
// req_tready is high only while the sequencer is idle, so one item is in work
// at a time. The result sits in an output register; the next item may be
// accepted meanwhile, and its result waits until that register is taken.
// Reset (synchronous) restores the register reset values, sets the belief to
// one half, the last measurement to closed and clears the done flag.
module binary_bayes_belief_update (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [23:0] feature_value
   input  logic [bbbu_pkg::REQ_DAT_W-1:0]     req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [16:0] belief_open, [17] measured_open, [18] belief_updated,
   // [19] done_res, [23:20] zero
   output logic [bbbu_pkg::RSP_DAT_W-1:0]     rsp_tdata,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [bbbu_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bbbu_pkg::CSR_DAT_W-1:0]     csr_data
);

   localparam int PROB_W = bbbu_pkg::PROB_W;
   localparam int THR_W  = bbbu_pkg::THR_W;
   localparam int PROD_W = bbbu_pkg::PROD_W;
   localparam int ACC_W  = bbbu_pkg::ACC_W;
   localparam int NUM_W  = bbbu_pkg::NUM_W;
   localparam int FRAC   = bbbu_pkg::FRAC_BITS;
   localparam int PO_W   = ACC_W - FRAC;
   localparam logic [PROB_W-1:0] ONE = bbbu_pkg::PROB_ONE;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_MUL_A = 4'd1;
   localparam logic [3:0] ST_MUL_B = 4'd2;
   localparam logic [3:0] ST_PRED  = 4'd3;
   localparam logic [3:0] ST_MUL_C = 4'd4;
   localparam logic [3:0] ST_MUL_D = 4'd5;
   localparam logic [3:0] ST_CHK   = 4'd6;
   localparam logic [3:0] ST_DIV   = 4'd7;
   localparam logic [3:0] ST_FIN   = 4'd8;

   // Configuration registers.
   logic [THR_W-1:0]  thr_ff;
   logic [PROB_W-1:0] too_ff, tco_ff, soo_ff, soc_ff, lvl_ff;

   // Filter state.
   logic [PROB_W-1:0] belief_ff, belief_in;
   logic              meas_ff, meas_in;
   logic              done_ff, done_in;
   logic              upd_ff, upd_in;

   // Sequencer and datapath.
   logic [3:0]        state_ff, state_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [NUM_W-1:0]  num_ff, num_in;
   logic [PROB_W-1:0] po_ff, po_in;

   // Output register.
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [bbbu_pkg::RSP_DAT_W-1:0] rsp_data_ff, rsp_data_in;

   logic [PROB_W-1:0] b_sat, too_sat, tco_sat, soo_sat, soc_sat, lvl_sat;
   logic [PROB_W-1:0] lo, lc, pc;
   logic [PROB_W-1:0] mul_a, mul_b;
   logic [PROD_W-1:0] prod;
   logic [PO_W-1:0]   acc_hi;
   logic              req_xfer;
   logic              rsp_free;

   bbbu_pkg::div_req_type div_req;
   bbbu_pkg::div_rsp_type div_rsp;

   bbbu_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      b_sat   = bbbu_pkg::sat_prob(belief_ff);
      too_sat = bbbu_pkg::sat_prob(too_ff);
      tco_sat = bbbu_pkg::sat_prob(tco_ff);
      soo_sat = bbbu_pkg::sat_prob(soo_ff);
      soc_sat = bbbu_pkg::sat_prob(soc_ff);
      lvl_sat = bbbu_pkg::sat_prob(lvl_ff);
      lo      = meas_ff ? soo_sat : ONE - soo_sat;
      lc      = meas_ff ? soc_sat : ONE - soc_sat;
      pc      = ONE - po_ff;
      acc_hi  = acc_ff[ACC_W-1:FRAC];
   end

   // The single multiplier serves the predict and the evidence terms in turn.
   always_comb begin
      case (state_ff)
         ST_MUL_A: begin
            mul_a = b_sat;
            mul_b = too_sat;
         end
         ST_MUL_B: begin
            mul_a = ONE - b_sat;
            mul_b = tco_sat;
         end
         ST_MUL_C: begin
            mul_a = lo;
            mul_b = po_ff;
         end
         ST_MUL_D: begin
            mul_a = lc;
            mul_b = pc;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod = PROD_W'(mul_a) * PROD_W'(mul_b);
   end

   always_comb begin
      state_in     = state_ff;
      acc_in       = acc_ff;
      num_in       = num_ff;
      po_in        = po_ff;
      belief_in    = belief_ff;
      meas_in      = meas_ff;
      done_in      = done_ff;
      upd_in       = upd_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      div_req      = '{start: 1'b0, num: num_ff, den: acc_ff[NUM_W-1:0]};

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               upd_in = 1'b0;
               if (done_ff) begin
                  // Once done, items leave the state untouched.
                  state_in = ST_FIN;
               end else begin
                  if (!req_tdata[bbbu_pkg::FEAT_W-1]) begin
                     meas_in = req_tdata[THR_W-1:0] < thr_ff;
                  end
                  state_in = ST_MUL_A;
               end
            end
         end
         ST_MUL_A: begin
            acc_in   = ACC_W'(prod);
            state_in = ST_MUL_B;
         end
         ST_MUL_B: begin
            acc_in   = acc_ff + ACC_W'(prod);
            state_in = ST_PRED;
         end
         ST_PRED: begin
            po_in    = (acc_hi > PO_W'(ONE)) ? ONE : acc_hi[PROB_W-1:0];
            state_in = ST_MUL_C;
         end
         ST_MUL_C: begin
            acc_in   = ACC_W'(prod);
            num_in   = prod[NUM_W-1:0];
            state_in = ST_MUL_D;
         end
         ST_MUL_D: begin
            acc_in   = acc_ff + ACC_W'(prod);
            state_in = ST_CHK;
         end
         ST_CHK: begin
            // Zero evidence leaves the belief as it was.
            if (acc_ff == '0) begin
               state_in = ST_FIN;
            end else begin
               div_req.start = 1'b1;
               state_in      = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               belief_in = div_rsp.quot;
               upd_in    = 1'b1;
               if (div_rsp.quot >= lvl_sat) begin
                  done_in = 1'b1;
               end
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'b0000, done_ff, upd_ff, meas_ff, belief_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         belief_ff    <= bbbu_pkg::PROB_HALF;
         meas_ff      <= 1'b0;
         done_ff      <= 1'b0;
         upd_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         belief_ff    <= belief_in;
         meas_ff      <= meas_in;
         done_ff      <= done_in;
         upd_ff       <= upd_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      num_ff      <= num_in;
      po_ff       <= po_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Configuration writes; indexes past the last register are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= bbbu_pkg::RST_FEATURE_THRESHOLD;
         too_ff <= bbbu_pkg::RST_TRANS_OPEN_TO_OPEN;
         tco_ff <= bbbu_pkg::RST_TRANS_CLOSED_TO_OPEN;
         soo_ff <= bbbu_pkg::RST_SENSE_OPEN_IF_OPEN;
         soc_ff <= bbbu_pkg::RST_SENSE_OPEN_IF_CLOSED;
         lvl_ff <= bbbu_pkg::RST_DONE_BELIEF_LEVEL;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            bbbu_pkg::REG_FEATURE_THRESHOLD:    thr_ff <= csr_data[THR_W-1:0];
            bbbu_pkg::REG_TRANS_OPEN_TO_OPEN:   too_ff <= csr_data[PROB_W-1:0];
            bbbu_pkg::REG_TRANS_CLOSED_TO_OPEN: tco_ff <= csr_data[PROB_W-1:0];
            bbbu_pkg::REG_SENSE_OPEN_IF_OPEN:   soo_ff <= csr_data[PROB_W-1:0];
            bbbu_pkg::REG_SENSE_OPEN_IF_CLOSED: soc_ff <= csr_data[PROB_W-1:0];
            bbbu_pkg::REG_DONE_BELIEF_LEVEL:    lvl_ff <= csr_data[PROB_W-1:0];
            default: begin
            end
         endcase
      end
   end

endmodule

/* hw/rtl/bbbu_divider.sv */
// Bit-serial restoring divider: floor(num * 2^16 / den) for num <= den, den != 0.
// One quotient bit per cycle, 17 bits in all. Depends on bbbu_pkg.
`timescale 1ns / 1ps

module bbbu_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  bbbu_pkg::div_req_type div_req,
   output bbbu_pkg::div_rsp_type div_rsp
);

   localparam int NUM_W     = bbbu_pkg::NUM_W;
   localparam int PROB_W    = bbbu_pkg::PROB_W;
   localparam int DIV_STEPS = bbbu_pkg::FRAC_BITS + 1;
   localparam int CNT_W     = $clog2(DIV_STEPS);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_STEPS - 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [NUM_W-1:0]  rem_ff, rem_in;
   logic [NUM_W-1:0]  den_ff, den_in;
   logic [PROB_W-1:0] quot_ff, quot_in;

   logic [NUM_W:0]    rem_shift;
   logic [NUM_W:0]    rem_diff;
   logic              rem_ge;

   // The first step compares the remainder as it is; later steps shift it first.
   always_comb begin
      rem_shift = (cnt_ff == '0) ? {1'b0, rem_ff} : {rem_ff, 1'b0};
      rem_ge    = rem_shift >= {1'b0, den_ff};
      rem_diff  = rem_shift - {1'b0, den_ff};
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = div_req.num;
         den_in  = div_req.den;
         quot_in = '0;
      end else if (busy_ff) begin
         rem_in  = rem_ge ? rem_diff[NUM_W-1:0] : rem_shift[NUM_W-1:0];
         quot_in = {quot_ff[PROB_W-2:0], rem_ge};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;

endmodule

/* tb/testbench.sv */
// Self-checking testbench for binary_bayes_belief_update, the two-state door Bayes filter.
// Depends on bbbu_pkg and the RTL of the block; the expected results come from a predictor
// kept here or, for some directed items, are given by hand, and are checked against every result transfer.
`timescale 1ns / 1ps

module testbench;

   localparam int PROB_W    = bbbu_pkg::PROB_W;
   localparam int THR_W     = bbbu_pkg::THR_W;
   localparam int FRAC_BITS = bbbu_pkg::FRAC_BITS;
   localparam int CSR_IDX_W = bbbu_pkg::CSR_IDX_W;
   localparam int CSR_DAT_W = bbbu_pkg::CSR_DAT_W;
   localparam int REQ_DAT_W = bbbu_pkg::REQ_DAT_W;
   localparam int RSP_DAT_W = bbbu_pkg::RSP_DAT_W;
   localparam logic [PROB_W-1:0] PROB_ONE  = bbbu_pkg::PROB_ONE;
   localparam logic [PROB_W-1:0] PROB_HALF = bbbu_pkg::PROB_HALF;

   // Register indexes the block must ignore.
   localparam logic [CSR_IDX_W-1:0] REG_UNMAPPED_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;
   localparam logic [63:0]          UNIT            = 64'(PROB_ONE);
   localparam int                   PHASE_ITEMS     = 135;
   localparam int                   RANDOM_PHASES   = 8;

   typedef struct packed {
      logic [PROB_W-1:0] belief;
      logic              meas_open;
      logic              updated;
      logic              done_flag;
   } door_result_type;

   typedef struct {
      bit                    is_write;
      logic [CSR_IDX_W-1:0]  reg_idx;
      logic [CSR_DAT_W-1:0]  reg_val;
      logic [REQ_DAT_W-1:0]  feature;
      bit                    typed;
      door_result_type       want;
   } stim_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DAT_W-1:0]  req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DAT_W-1:0]  rsp_tdata;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DAT_W-1:0]  csr_data;

   // Predictor copy of the configuration and the filter state.
   logic [THR_W-1:0]      cfg_threshold;
   logic [PROB_W-1:0]     cfg_stay_open;
   logic [PROB_W-1:0]     cfg_become_open;
   logic [PROB_W-1:0]     cfg_hit_if_open;
   logic [PROB_W-1:0]     cfg_hit_if_closed;
   logic [PROB_W-1:0]     cfg_done_level;
   logic [PROB_W-1:0]     door_belief;
   logic                  door_meas_open;
   logic                  door_done;

   door_result_type       belief_due[$];
   stim_row_type          directed_rows[$];
   door_result_type       rsp_seen;
   door_result_type       rsp_due;

   int                    send_gap_pct;
   int                    rsp_stall_pct;
   int                    mismatch_count;
   int                    items_sent;
   int                    results_seen;
   int                    reg_writes;
   int                    settings_used;

   binary_bayes_belief_update dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   function automatic logic [63:0] clamp_unit(input logic [63:0] v);
      return (v > UNIT) ? UNIT : v;
   endfunction

   function automatic void apply_reg_write(input logic [CSR_IDX_W-1:0] idx,
                                           input logic [CSR_DAT_W-1:0] val);
      case (idx)
         bbbu_pkg::REG_FEATURE_THRESHOLD:    cfg_threshold     = val[THR_W-1:0];
         bbbu_pkg::REG_TRANS_OPEN_TO_OPEN:   cfg_stay_open     = val[PROB_W-1:0];
         bbbu_pkg::REG_TRANS_CLOSED_TO_OPEN: cfg_become_open   = val[PROB_W-1:0];
         bbbu_pkg::REG_SENSE_OPEN_IF_OPEN:   cfg_hit_if_open   = val[PROB_W-1:0];
         bbbu_pkg::REG_SENSE_OPEN_IF_CLOSED: cfg_hit_if_closed = val[PROB_W-1:0];
         bbbu_pkg::REG_DONE_BELIEF_LEVEL:    cfg_done_level    = val[PROB_W-1:0];
         default: ;
      endcase
   endfunction

   // One filter step, unless done: predict with the transition model, then weigh by the sensor model.
   function automatic door_result_type predict_door_step(input logic [REQ_DAT_W-1:0] feat);
      logic [63:0]     stay, become, hit_open, hit_closed, prior, p_open, p_closed;
      logic [63:0]     like_open, like_closed, num, den, quot;
      logic            upd;
      door_result_type r;
      upd = 1'b0;
      if (!door_done) begin
         stay       = clamp_unit(64'(cfg_stay_open));
         become     = clamp_unit(64'(cfg_become_open));
         hit_open   = clamp_unit(64'(cfg_hit_if_open));
         hit_closed = clamp_unit(64'(cfg_hit_if_closed));
         prior      = clamp_unit(64'(door_belief));
         if (!feat[REQ_DAT_W-1])
            door_meas_open = (feat[THR_W-1:0] < cfg_threshold);
         p_open = (prior * stay + (UNIT - prior) * become) >> FRAC_BITS;
         if (p_open > UNIT)
            p_open = UNIT;
         p_closed = UNIT - p_open;
         if (door_meas_open) begin
            like_open   = hit_open;
            like_closed = hit_closed;
         end else begin
            like_open   = UNIT - hit_open;
            like_closed = UNIT - hit_closed;
         end
         num = like_open * p_open;
         den = num + like_closed * p_closed;
         if (den != 0) begin
            quot        = (num << FRAC_BITS) / den;
            door_belief = quot[PROB_W-1:0];
            upd         = 1'b1;
            if (64'(door_belief) >= clamp_unit(64'(cfg_done_level)))
               door_done = 1'b1;
         end
      end
      r.belief    = door_belief;
      r.meas_open = door_meas_open;
      r.updated   = upd;
      r.done_flag = door_done;
      return r;
   endfunction

   // Mostly features near the threshold or anywhere valid; the rest invalid (negative).
   function automatic logic [REQ_DAT_W-1:0] rand_feature();
      int pick;
      int near;
      pick = $urandom_range(9);
      if (pick < 3)
         return {1'b1, 23'($urandom)};
      if (pick < 6) begin
         near = int'(cfg_threshold) + int'($urandom_range(512)) - 256;
         if (near < 0)
            near = 0;
         if (near > 23'h7FFFFF)
            near = 23'h7FFFFF;
         return {1'b0, 23'(near)};
      end
      return {1'b0, 23'($urandom)};
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      mismatch_count++;
   endtask

   task automatic add_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] val);
      stim_row_type row;
      row          = '{default: '0};
      row.is_write = 1'b1;
      row.reg_idx  = idx;
      row.reg_val  = val;
      directed_rows.push_back(row);
   endtask

   task automatic add_item(input logic [REQ_DAT_W-1:0] feat, input bit typed,
                           input logic [PROB_W-1:0] belief, input logic meas,
                           input logic upd, input logic fin);
      stim_row_type row;
      row                = '{default: '0};
      row.feature        = feat;
      row.typed          = typed;
      row.want.belief    = belief;
      row.want.meas_open = meas;
      row.want.updated   = upd;
      row.want.done_flag = fin;
      directed_rows.push_back(row);
   endtask

   // Called at a falling edge; returns at a falling edge with req_tvalid still high.
   task automatic send_feature(input logic [REQ_DAT_W-1:0] feat, input bit typed,
                               input door_result_type typed_res);
      door_result_type predicted;
      while ($urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= feat;
      do @(posedge clock); while (!req_tready);
      predicted = predict_door_step(feat);
      belief_due.push_back(typed ? typed_res : predicted);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic end_burst();
      req_tvalid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      while (belief_due.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      apply_reg_write(idx, val);
      reg_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // Probability writes carry junk above bit 16, which the block must drop.
   task automatic write_prob(input logic [CSR_IDX_W-1:0] idx, input logic [PROB_W-1:0] val);
      write_reg(idx, {6'($urandom), val});
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         rsp_seen.belief    = rsp_tdata[16:0];
         rsp_seen.meas_open = rsp_tdata[17];
         rsp_seen.updated   = rsp_tdata[18];
         rsp_seen.done_flag = rsp_tdata[19];
         if (belief_due.size() == 0) begin
            report_mismatch("result with nothing pending", 32'(rsp_tdata), 32'd0);
         end else begin
            rsp_due = belief_due.pop_front();
            if (rsp_seen.belief !== rsp_due.belief)
               report_mismatch("belief_open", 32'(rsp_seen.belief), 32'(rsp_due.belief));
            if (rsp_seen.meas_open !== rsp_due.meas_open)
               report_mismatch("measured_open", 32'(rsp_seen.meas_open),
                               32'(rsp_due.meas_open));
            if (rsp_seen.updated !== rsp_due.updated)
               report_mismatch("belief_updated", 32'(rsp_seen.updated), 32'(rsp_due.updated));
            if (rsp_seen.done_flag !== rsp_due.done_flag)
               report_mismatch("done_res", 32'(rsp_seen.done_flag), 32'(rsp_due.done_flag));
         end
      end
   end

   initial begin
      #2_000_000;
      $display("Timed out with %0d results still pending.", belief_due.size());
      $display("** binary_bayes_belief_update: FAILED **");
      $finish;
   end

   initial begin
      int ph;
      int n;
      int kind;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      csr_valid     = 1'b0;
      csr_index     = '0;
      csr_data      = '0;
      send_gap_pct  = 0;
      rsp_stall_pct = 0;
      items_sent    = 0;
      reg_writes    = 0;
      settings_used = 1;

      cfg_threshold     = bbbu_pkg::RST_FEATURE_THRESHOLD;
      cfg_stay_open     = bbbu_pkg::RST_TRANS_OPEN_TO_OPEN;
      cfg_become_open   = bbbu_pkg::RST_TRANS_CLOSED_TO_OPEN;
      cfg_hit_if_open   = bbbu_pkg::RST_SENSE_OPEN_IF_OPEN;
      cfg_hit_if_closed = bbbu_pkg::RST_SENSE_OPEN_IF_CLOSED;
      cfg_done_level    = bbbu_pkg::RST_DONE_BELIEF_LEVEL;
      door_belief       = PROB_HALF;
      door_meas_open    = 1'b0;
      door_done         = 1'b0;

      // Zero evidence must leave the belief alone and skip the done check, even at level zero.
      add_write(bbbu_pkg::REG_DONE_BELIEF_LEVEL, 23'd0);
      add_write(bbbu_pkg::REG_SENSE_OPEN_IF_OPEN, 23'd0);
      add_write(bbbu_pkg::REG_SENSE_OPEN_IF_CLOSED, 23'd0);
      add_item(24'h000000, 1'b1, PROB_HALF, 1'b1, 1'b0, 1'b0);
      add_item(24'hFFFFFF, 1'b1, PROB_HALF, 1'b1, 1'b0, 1'b0);
      add_write(bbbu_pkg::REG_SENSE_OPEN_IF_OPEN, 23'h01FFFF);
      add_write(bbbu_pkg::REG_SENSE_OPEN_IF_CLOSED, 23'(PROB_ONE));
      add_item(24'h7FFFFF, 1'b1, PROB_HALF, 1'b0, 1'b0, 1'b0);
      // Saturated level keeps the done flag out of reach from here on.
      add_write(bbbu_pkg::REG_DONE_BELIEF_LEVEL, 23'h01FFFF);
      // Identity transition and flat sensor: the belief is rewritten with its own value.
      add_write(bbbu_pkg::REG_TRANS_OPEN_TO_OPEN, 23'h01FFFF);
      add_write(bbbu_pkg::REG_TRANS_CLOSED_TO_OPEN, 23'd0);
      add_item(24'h000000, 1'b1, PROB_HALF, 1'b1, 1'b1, 1'b0);
      add_write(REG_UNMAPPED_LO, 23'h7FFFFF);
      add_write(REG_UNMAPPED_HI, 23'd0);
      add_item(24'h800000, 1'b1, PROB_HALF, 1'b1, 1'b1, 1'b0);
      add_write(bbbu_pkg::REG_TRANS_OPEN_TO_OPEN, 23'(bbbu_pkg::RST_TRANS_OPEN_TO_OPEN));
      add_write(bbbu_pkg::REG_TRANS_CLOSED_TO_OPEN, 23'(bbbu_pkg::RST_TRANS_CLOSED_TO_OPEN));
      add_write(bbbu_pkg::REG_SENSE_OPEN_IF_OPEN, 23'(bbbu_pkg::RST_SENSE_OPEN_IF_OPEN));
      add_write(bbbu_pkg::REG_SENSE_OPEN_IF_CLOSED, 23'(bbbu_pkg::RST_SENSE_OPEN_IF_CLOSED));
      add_item(24'(bbbu_pkg::RST_FEATURE_THRESHOLD - 1), 1'b0, '0, 1'b0, 1'b0, 1'b0);
      add_item(24'(bbbu_pkg::RST_FEATURE_THRESHOLD), 1'b0, '0, 1'b0, 1'b0, 1'b0);
      add_item(24'h7FFFFF, 1'b0, '0, 1'b0, 1'b0, 1'b0);
      add_write(bbbu_pkg::REG_FEATURE_THRESHOLD, 23'd0);
      add_item(24'h000000, 1'b0, '0, 1'b0, 1'b0, 1'b0);
      add_write(bbbu_pkg::REG_FEATURE_THRESHOLD, 23'h7FFFFF);
      add_item(24'h7FFFFE, 1'b0, '0, 1'b0, 1'b0, 1'b0);
      add_item(24'h7FFFFF, 1'b0, '0, 1'b0, 1'b0, 1'b0);
      add_item(24'hFFFFFF, 1'b0, '0, 1'b0, 1'b0, 1'b0);

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_write) begin
            end_burst();
            wait_drained();
            write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
            settings_used++;
         end else begin
            send_feature(directed_rows[i].feature, directed_rows[i].typed, directed_rows[i].want);
         end
      end

      // Random phases. Settings keep the closed-to-open transition below one and the
      // closed-side sensor strictly inside (0, 1), so the belief never reaches one and
      // done stays clear until the last phase.
      for (ph = 0; ph < RANDOM_PHASES; ph++) begin
         end_burst();
         wait_drained();
         case (ph % 4)
            0: begin send_gap_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_gap_pct = 58; rsp_stall_pct = 0;  end
            2: begin send_gap_pct = 0;  rsp_stall_pct = 58; end
            default: begin send_gap_pct = 13; rsp_stall_pct = 13; end
         endcase
         kind = ph % 4;
         case (kind)
            0: write_reg(bbbu_pkg::REG_FEATURE_THRESHOLD, 23'd0);
            1: write_reg(bbbu_pkg::REG_FEATURE_THRESHOLD, 23'h7FFFFF);
            2: write_reg(bbbu_pkg::REG_FEATURE_THRESHOLD, 23'($urandom));
            default: write_reg(bbbu_pkg::REG_FEATURE_THRESHOLD, 23'($urandom_range(20'hFFFFF)));
         endcase
         kind = (ph + 1) % 4;
         case (kind)
            0: write_prob(bbbu_pkg::REG_TRANS_OPEN_TO_OPEN, 17'd0);
            1: write_prob(bbbu_pkg::REG_TRANS_OPEN_TO_OPEN, PROB_ONE);
            2: write_prob(bbbu_pkg::REG_TRANS_OPEN_TO_OPEN, 17'h1FFFF);
            default: write_prob(bbbu_pkg::REG_TRANS_OPEN_TO_OPEN,
                                17'($urandom_range(int'(PROB_ONE))));
         endcase
         kind = (ph + 2) % 4;
         case (kind)
            0: write_prob(bbbu_pkg::REG_TRANS_CLOSED_TO_OPEN, 17'd0);
            1: write_prob(bbbu_pkg::REG_TRANS_CLOSED_TO_OPEN, PROB_ONE - 17'd1);
            default: write_prob(bbbu_pkg::REG_TRANS_CLOSED_TO_OPEN,
                                17'($urandom_range(int'(PROB_ONE) - 1)));
         endcase
         kind = (ph + 3) % 4;
         case (kind)
            0: write_prob(bbbu_pkg::REG_SENSE_OPEN_IF_OPEN, 17'd0);
            1: write_prob(bbbu_pkg::REG_SENSE_OPEN_IF_OPEN, PROB_ONE);
            2: write_prob(bbbu_pkg::REG_SENSE_OPEN_IF_OPEN, 17'($urandom_range(17'h1FFFF)));
            default: write_prob(bbbu_pkg::REG_SENSE_OPEN_IF_OPEN,
                                17'($urandom_range(int'(PROB_ONE))));
         endcase
         kind = ph % 3;
         case (kind)
            0: write_prob(bbbu_pkg::REG_SENSE_OPEN_IF_CLOSED, 17'd1);
            1: write_prob(bbbu_pkg::REG_SENSE_OPEN_IF_CLOSED, PROB_ONE - 17'd1);
            default: write_prob(bbbu_pkg::REG_SENSE_OPEN_IF_CLOSED,
                                17'($urandom_range(int'(PROB_ONE) - 1, 1)));
         endcase
         kind = ph % 3;
         case (kind)
            0: write_prob(bbbu_pkg::REG_DONE_BELIEF_LEVEL, PROB_ONE);
            1: write_prob(bbbu_pkg::REG_DONE_BELIEF_LEVEL, 17'h1FFFF);
            default: write_prob(bbbu_pkg::REG_DONE_BELIEF_LEVEL,
                                17'($urandom_range(17'h1FFFF, int'(PROB_ONE))));
         endcase
         settings_used++;
         for (n = 0; n < PHASE_ITEMS; n++) begin
            // Once, the sender holds off until every result is back.
            if (ph == 2 && n == PHASE_ITEMS / 2) begin
               end_burst();
               wait_drained();
            end
            send_feature(rand_feature(), 1'b0, '0);
         end
      end

      // Last phase: certain transition to open drives the belief to one, which sets
      // the sticky done flag; every item after that must be ignored.
      end_burst();
      wait_drained();
      send_gap_pct  = 13;
      rsp_stall_pct = 13;
      write_reg(bbbu_pkg::REG_FEATURE_THRESHOLD, 23'(bbbu_pkg::RST_FEATURE_THRESHOLD));
      write_prob(bbbu_pkg::REG_TRANS_OPEN_TO_OPEN, bbbu_pkg::RST_TRANS_OPEN_TO_OPEN);
      write_prob(bbbu_pkg::REG_TRANS_CLOSED_TO_OPEN, PROB_ONE);
      write_prob(bbbu_pkg::REG_SENSE_OPEN_IF_OPEN, bbbu_pkg::RST_SENSE_OPEN_IF_OPEN);
      write_prob(bbbu_pkg::REG_SENSE_OPEN_IF_CLOSED, bbbu_pkg::RST_SENSE_OPEN_IF_CLOSED);
      write_prob(bbbu_pkg::REG_DONE_BELIEF_LEVEL, bbbu_pkg::RST_DONE_BELIEF_LEVEL);
      settings_used++;
      for (n = 0; n < 25; n++)
         send_feature(rand_feature(), 1'b0, '0);

      end_burst();
      wait_drained();
      repeat (30) @(negedge clock);

      $display("Run covered %0d feature items under %0d register settings (%0d writes),",
               items_sent, settings_used, reg_writes);
      $display("%0d results compared; idle patterns: none, sender gaps, receiver stalls, both;",
               results_seen);
      $display("done flag reached: %0d.", door_done);
      if (mismatch_count == 0 && belief_due.size() == 0) begin
         $display("** binary_bayes_belief_update: PASSED **");
      end else begin
         $display("%0d mismatches, %0d results never arrived.", mismatch_count,
                  belief_due.size());
         $display("** binary_bayes_belief_update: FAILED **");
      end
      $finish;
   end

endmodule
